// ----- hw/rtl/tcec_pkg.sv -----
// tcec_pkg: shared types for the touch contact event classifier.
// Used by tcec_cell, the top level and the port checker. No dependencies.
package tcec_pkg;

    typedef enum logic [1:0] {
        EV_DOWN = 2'd0,
        EV_UP   = 2'd1,
        EV_MOVE = 2'd2,
        EV_SAME = 2'd3
    } ev_kind_t;

    // One touch report as held in the request stage and in each cell
    typedef struct packed {
        logic [15:0] contact_id;
        logic        on_surface;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } report_t;

    // Match result handed from cell to cell; the lowest hit wins
    typedef struct packed {
        logic     found;
        ev_kind_t kind;
    } link_t;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

endpackage

// ----- hw/rtl/tcec_cell.sv -----
// tcec_cell: one slot of the contact table. Holds one stored report,
// matches it against the request and passes the match result down the chain.
// Depends on tcec_pkg.
module tcec_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 4
) (
    input  logic             clk,
    input  tcec_pkg::report_t req,
    input  logic [CNT_W-1:0] count,
    input  logic             go,
    input  logic             found_all,
    input  tcec_pkg::link_t  link_in,
    output tcec_pkg::link_t  link_out
);
    import tcec_pkg::*;

    report_t  entry_reg;
    logic     active;
    logic     hit;
    logic     first_hit;
    logic     append_here;
    ev_kind_t my_kind;

    assign active    = CNT_W'(IDX) < count;
    assign hit       = active && (entry_reg.contact_id == req.contact_id);
    assign first_hit = hit && !link_in.found;
    // slot just past the last valid entry takes an unknown id
    assign append_here = !found_all && (count == CNT_W'(IDX));

    always_comb
    begin
        if (entry_reg.on_surface && req.on_surface)
        begin
            if (entry_reg.pos_x == req.pos_x && entry_reg.pos_y == req.pos_y)
                my_kind = EV_SAME;
            else
                my_kind = EV_MOVE;
        end
        else if (!entry_reg.on_surface && req.on_surface)
            my_kind = EV_DOWN;
        else
            my_kind = EV_UP;
    end

    always_comb
    begin
        link_out = link_in;
        if (first_hit)
        begin
            link_out.found = 1'b1;
            link_out.kind  = my_kind;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && (first_hit || append_here))
            entry_reg <= req;
    end

endmodule

// ----- hw/rtl/touch_contact_event_classifier_top.sv -----
// touch_contact_event_classifier_top: classifies touch reports against a
// table of the last report per contact id. Depends on tcec_pkg, tcec_cell.
//
// Usage:
//   Slave channel (s_t*) takes one touch report per request: contact id,
//   on-surface flag, x and y. Master channel (m_t*) returns one result per
//   report: event kind (down, up, move, move unchanged) and a table-full flag.
//   Every report gives exactly one result, in order.
// Flow:
//   A report is registered on acceptance, then matched through the chain
//   of MAX_CONTACTS table cells once the output is free, when the table is
//   updated and the result registered. s_tready is low while a report is
//   held, until it is matched. The chain of cells sets the clock period.
// Reset:
//   rst_n clears the entry count and all handshake state; table entries are
//   only read once counted, so they need no clearing.
// Stall:
//   While m_tready is low the result stays on m_tdata; a second report can
//   still be taken and waits in the request stage until the output frees.
module touch_contact_event_classifier_top #(
    parameter int MAX_CONTACTS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] contact_id, [16] on_surface, [32:17] pos_x, [48:33] pos_y, rest zero
    input  logic [tcec_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] event_kind, [2] table_full, rest zero
    output logic [tcec_pkg::M_TDATA_W-1:0] m_tdata
);
    import tcec_pkg::*;

    localparam int CNT_W = $clog2(MAX_CONTACTS + 1);

    report_t          req_reg;
    logic             req_valid_reg;
    logic             req_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    ev_kind_t         out_kind_reg;
    ev_kind_t         out_kind_next;
    logic             out_full_reg;
    logic             out_full_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic  s_accept;
    logic  go;
    logic  found_all;
    logic  room;
    link_t link [0:MAX_CONTACTS];

    assign s_tready = !req_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign go       = req_valid_reg && (!out_valid_reg || m_tready);

    assign link[0]   = '0;
    assign found_all = link[MAX_CONTACTS].found;
    assign room      = count_reg < CNT_W'(MAX_CONTACTS);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_CONTACTS; gi++)
        begin : g_cell
            tcec_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .req       (req_reg),
                .count     (count_reg),
                .go        (go),
                .found_all (found_all),
                .link_in   (link[gi]),
                .link_out  (link[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        req_valid_next = req_valid_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_full_next  = out_full_reg;
        count_next     = count_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        if (go)
        begin
            req_valid_next = 1'b0;
            out_valid_next = 1'b1;
            out_full_next  = 1'b0;
            if (found_all)
                out_kind_next = link[MAX_CONTACTS].kind;
            else
            begin
                if (!req_reg.on_surface)
                    out_kind_next = EV_UP;
                else if (count_reg == '0)
                    out_kind_next = EV_DOWN;
                else
                    out_kind_next = EV_MOVE;
                if (room)
                    count_next = count_reg + CNT_W'(1);
                else
                    out_full_next = 1'b1;
            end
        end

        if (s_accept)
            req_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            req_reg.contact_id <= s_tdata[15:0];
            req_reg.on_surface <= s_tdata[16];
            req_reg.pos_x      <= s_tdata[32:17];
            req_reg.pos_y      <= s_tdata[48:33];
        end
        out_kind_reg <= out_kind_next;
        out_full_reg <= out_full_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 3)'(0), out_full_reg, out_kind_reg};

endmodule

// ----- hw/rtl/tcec_checker.sv -----
// tcec_checker: port-level checks for the touch contact event classifier,
// bound to the top level. Depends on tcec_pkg.
module tcec_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [tcec_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tcec_pkg::M_TDATA_W-1:0] m_tdata
);
    import tcec_pkg::*;

    // stalled result stays valid
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one request at a time: s_tready drops after every acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken during match cycle");

    // full flag only on an unknown id, which gives move or up
    a_full_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |->
            (m_tdata[1:0] == EV_MOVE) || (m_tdata[1:0] == EV_UP))
        else $error("table full with wrong event kind");

    // a new result comes from a request held in the match stage
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a pending request");

endmodule

bind touch_contact_event_classifier_top tcec_checker u_tcec_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// tb: self-checking bench for touch_contact_event_classifier_top.
// Depends on tcec_pkg and the classifier RTL; a local contact table predicts each event.
module tb;
    import tcec_pkg::*;

    localparam int MAX_CONTACTS   = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 300;

    typedef struct packed {
        ev_kind_t kind;
        logic     full;
    } touch_event_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // predicted contact table
    logic [15:0] tbl_id [MAX_CONTACTS];
    logic        tbl_on [MAX_CONTACTS];
    logic [15:0] tbl_x  [MAX_CONTACTS];
    logic [15:0] tbl_y  [MAX_CONTACTS];
    int          tbl_count = 0;

    touch_event_t pending_events[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;
    int reports_sent  = 0;
    int kind_seen [4] = '{default: 0};
    int full_seen     = 0;

    touch_contact_event_classifier_top #(
        .MAX_CONTACTS (MAX_CONTACTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Classify one report against the table, then update the table
    function automatic touch_event_t classify_report(input logic [15:0] id, input logic on,
                                                     input logic [15:0] x, input logic [15:0] y);
        touch_event_t ev;
        int hit;
        ev.full = 1'b0;
        ev.kind = EV_UP;
        hit = -1;
        for (int i = 0; i < tbl_count; i++)
            if (hit < 0 && tbl_id[i] == id)
                hit = i;
        if (hit >= 0)
        begin
            if (tbl_on[hit] && on)
                ev.kind = (tbl_x[hit] == x && tbl_y[hit] == y) ? EV_SAME : EV_MOVE;
            else if (!tbl_on[hit] && on)
                ev.kind = EV_DOWN;
            else
                ev.kind = EV_UP;
        end
        else
        begin
            // new on-surface contact: down on an empty table, else a move; off-surface gives up
            if (tbl_count == 0)
                ev.kind = on ? EV_DOWN : EV_UP;
            else
                ev.kind = on ? EV_MOVE : EV_UP;
            if (tbl_count < MAX_CONTACTS)
            begin
                hit = tbl_count;
                tbl_count++;
            end
            else
                ev.full = 1'b1;
        end
        if (hit >= 0)
        begin
            tbl_id[hit] = id;
            tbl_on[hit] = on;
            tbl_x[hit]  = x;
            tbl_y[hit]  = y;
        end
        return ev;
    endfunction

    // Offer one report, wait for the request to be taken, log its expected event
    task automatic send_report(input logic [15:0] id, input logic on,
                               input logic [15:0] x, input logic [15:0] y);
        touch_event_t ev;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, y, x, on, id};
        do
            @(posedge clk);
        while (!s_tready);
        ev = classify_report(id, on, x, y);
        pending_events.push_back(ev);
        reports_sent++;
        kind_seen[ev.kind]++;
        if (ev.full)
            full_seen++;
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Result checker
    always @(posedge clk)
    begin
        touch_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no report pending: kind %0d full %0d",
                             $time, m_tdata[1:0], m_tdata[2]);
            end
            else
            begin
                want = pending_events.pop_front();
                if (m_tdata[1:0] !== want.kind || m_tdata[2] !== want.full)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: event differs: expected kind %0d full %0d, ",
                                  "got kind %0d full %0d"},
                                 $time, want.kind, want.full, m_tdata[1:0], m_tdata[2]);
                end
            end
        end
    end

    // Watchdog on cycles where neither side moves a request
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d events outstanding",
                         quiet_cycles, pending_events.size());
                $display("touch_contact_event_classifier_top: mismatch");
                $finish;
            end
        end
    end

    // Only report ever seen on an empty table
    task automatic test_empty_table();
        send_report(16'h0000, 1'b0, 16'h0000, 16'h0000);
    endtask

    // Every stored/new on-surface combination on one known contact
    task automatic test_transitions();
        send_report(16'h0000, 1'b1, 16'h0000, 16'h0000);
        send_report(16'h0000, 1'b1, 16'h0000, 16'h0000);
        send_report(16'h0000, 1'b1, 16'hFFFF, 16'hFFFF);
        send_report(16'h0000, 1'b1, 16'hFFFF, 16'h0000);
        send_report(16'h0000, 1'b1, 16'h0000, 16'h0000);
        send_report(16'h0000, 1'b0, 16'h0000, 16'h0000);
        send_report(16'h0000, 1'b0, 16'hFFFF, 16'hFFFF);
    endtask

    // New contacts appended until the table is full
    task automatic test_append();
        int i;
        send_report(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
        send_report(16'hFFFF, 1'b0, 16'h5555, 16'hAAAA);
        send_report(16'h0001, 1'b0, 16'hAAAA, 16'h5555);
        for (i = 2; i <= 6; i++)
            send_report(16'(i), 1'b1, 16'(i * 16'h1111), 16'(16'hFFFF - i));
    endtask

    // Unknown contacts on a full table, then known ones still tracked
    task automatic test_table_full();
        send_report(16'h1234, 1'b1, 16'h0100, 16'h0200);
        send_report(16'hBEEF, 1'b0, 16'hFFFF, 16'h0000);
        send_report(16'h0001, 1'b1, 16'h0000, 16'hFFFF);
        send_report(16'h0003, 1'b1, tbl_x[4], tbl_y[4]);
        send_report(16'hFFFF, 1'b1, 16'h8000, 16'h0001);
    endtask

    // Mostly known contacts with held, half-held or corner positions; some strangers
    task automatic test_random_traffic(input int n, input int idle_pct, input int stall);
        logic [15:0] id, x, y;
        logic        on;
        int          k, i, slot, pick;
        bit          known;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            on   = ($urandom_range(3) != 0);
            x    = 16'($urandom_range(16'hFFFF));
            y    = 16'($urandom_range(16'hFFFF));
            slot = $urandom_range(tbl_count - 1);
            id   = tbl_id[slot];
            if (pick < 70)
            begin
                case ($urandom_range(3))
                    0, 1:
                    begin
                        x = tbl_x[slot];
                        y = tbl_y[slot];
                    end
                    2: x = tbl_x[slot];
                    default: y = tbl_y[slot];
                endcase
            end
            else if (pick < 90)
            begin
                do
                begin
                    id    = 16'($urandom_range(16'hFFFF));
                    known = 1'b0;
                    for (i = 0; i < tbl_count; i++)
                        if (tbl_id[i] == id)
                            known = 1'b1;
                end
                while (known);
            end
            else
            begin
                x = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                y = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            send_report(id, on, x, y);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_transitions();
        test_append();
        test_table_full();
        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_random_traffic(PHASE_ITEMS, 46, 0);
        test_random_traffic(PHASE_ITEMS, 0, 46);
        test_random_traffic(PHASE_ITEMS, 24, 24);
        s_tvalid <= 1'b0;

        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display({"%0d reports over four idle/stall phases: ",
                  "%0d down, %0d up, %0d move, %0d unchanged"},
                 reports_sent, kind_seen[EV_DOWN], kind_seen[EV_UP], kind_seen[EV_MOVE],
                 kind_seen[EV_SAME]);
        $display("%0d new contacts rejected by the full table, %0d bad events",
                 full_seen, mismatches);
        if (mismatches == 0)
            $display("touch_contact_event_classifier_top: match");
        else
            $display("touch_contact_event_classifier_top: mismatch");
        $finish;
    end

endmodule
